// ===== hw/rtl/hrhp_pkg.sv =====
`default_nettype none

package hrhp_pkg;

    typedef logic [7:0] t_byte;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_new;
    } t_in_item;

    typedef struct packed {
        logic [7:0] byte_out;
        logic [2:0] byte_role;
        logic [2:0] event_code;
        logic [2:0] method_code;
        logic [1:0] version_code;
        logic       keep_alive;
    } t_out_item;

    // byte roles
    localparam logic [2:0] ROLE_METHOD  = 3'd0;
    localparam logic [2:0] ROLE_PATH    = 3'd1;
    localparam logic [2:0] ROLE_QUERY   = 3'd2;
    localparam logic [2:0] ROLE_VERSION = 3'd3;
    localparam logic [2:0] ROLE_HNAME   = 3'd4;
    localparam logic [2:0] ROLE_HVALUE  = 3'd5;
    localparam logic [2:0] ROLE_DELIM   = 3'd6;
    localparam logic [2:0] ROLE_IGNORED = 3'd7;

    // events
    localparam logic [2:0] EV_NONE     = 3'd0;
    localparam logic [2:0] EV_REQ_LINE = 3'd1;
    localparam logic [2:0] EV_HDR_LINE = 3'd2;
    localparam logic [2:0] EV_COMPLETE = 3'd3;
    localparam logic [2:0] EV_ERROR    = 3'd4;

    // methods
    localparam logic [2:0] METH_INVALID = 3'd0;
    localparam logic [2:0] METH_GET     = 3'd1;
    localparam logic [2:0] METH_POST    = 3'd2;
    localparam logic [2:0] METH_HEAD    = 3'd3;
    localparam logic [2:0] METH_PUT     = 3'd4;
    localparam logic [2:0] METH_DELETE  = 3'd5;

    // versions
    localparam logic [1:0] VER_UNKNOWN = 2'd0;
    localparam logic [1:0] VER_1_0     = 2'd1;
    localparam logic [1:0] VER_1_1     = 2'd2;

    // connection header value classes
    localparam logic [1:0] CONN_ABSENT = 2'd0;
    localparam logic [1:0] CONN_KA     = 2'd1;
    localparam logic [1:0] CONN_CLOSE  = 2'd2;
    localparam logic [1:0] CONN_OTHER  = 2'd3;

    // characters
    localparam t_byte CH_SPACE = 8'h20;
    localparam t_byte CH_CR    = 8'h0D;
    localparam t_byte CH_LF    = 8'h0A;
    localparam t_byte CH_COLON = 8'h3A;
    localparam t_byte CH_QMARK = 8'h3F;
    localparam t_byte CH_ZERO  = 8'h30;
    localparam t_byte CH_ONE   = 8'h31;

    // method text, right aligned in six bytes
    localparam logic [47:0] TXT_GET    = 48'h000000474554;
    localparam logic [47:0] TXT_POST   = 48'h0000504F5354;
    localparam logic [47:0] TXT_HEAD   = 48'h000048454144;
    localparam logic [47:0] TXT_PUT    = 48'h000000505554;
    localparam logic [47:0] TXT_DELETE = 48'h44454C455445;

    // "HTTP/1."
    function automatic t_byte ver_char(input logic [3:0] idx);
        t_byte c;
        case (idx)
            4'd0:    c = 8'h48;
            4'd1:    c = 8'h54;
            4'd2:    c = 8'h54;
            4'd3:    c = 8'h50;
            4'd4:    c = 8'h2F;
            4'd5:    c = 8'h31;
            4'd6:    c = 8'h2E;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // "Connection"
    function automatic t_byte conn_char(input logic [3:0] idx);
        t_byte c;
        case (idx)
            4'd0:    c = 8'h43;
            4'd1:    c = 8'h6F;
            4'd2:    c = 8'h6E;
            4'd3:    c = 8'h6E;
            4'd4:    c = 8'h65;
            4'd5:    c = 8'h63;
            4'd6:    c = 8'h74;
            4'd7:    c = 8'h69;
            4'd8:    c = 8'h6F;
            4'd9:    c = 8'h6E;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // "Keep-Alive"
    function automatic t_byte ka_char(input logic [3:0] idx);
        t_byte c;
        case (idx)
            4'd0:    c = 8'h4B;
            4'd1:    c = 8'h65;
            4'd2:    c = 8'h65;
            4'd3:    c = 8'h70;
            4'd4:    c = 8'h2D;
            4'd5:    c = 8'h41;
            4'd6:    c = 8'h6C;
            4'd7:    c = 8'h69;
            4'd8:    c = 8'h76;
            4'd9:    c = 8'h65;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // "close"
    function automatic t_byte close_char(input logic [3:0] idx);
        t_byte c;
        case (idx)
            4'd0:    c = 8'h63;
            4'd1:    c = 8'h6C;
            4'd2:    c = 8'h6F;
            4'd3:    c = 8'h73;
            4'd4:    c = 8'h65;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/hrhp_if.sv =====
`default_nettype none

interface hrhp_in_if;
    logic               valid;
    logic               ready;
    hrhp_pkg::t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface hrhp_out_if;
    logic                valid;
    logic                ready;
    hrhp_pkg::t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/http_request_head_parser.sv =====
// HTTP/1.x request head tagger. Each item on i_in carries one byte of the
// request stream; each byte yields exactly one item on o_out with the byte,
// its role (method, path, query, version, header name, header value,
// delimiter, ignored), an event (request line accepted, header line ended,
// request complete, request error), the method and version found so far and,
// on request complete, the keep-alive verdict. Setting start_new on a byte
// clears the parse state before that byte is handled. Throughput is one byte
// per clock: the whole per-byte decision is one pass of narrow compares from
// the state registers into the output register, and a new byte is taken
// whenever the output register is empty or being drained in the same cycle.
// o_out.valid rises in the cycle after a byte is accepted. After an error or a
// completed head every byte is tagged ignored until the next start_new.
`default_nettype none

module http_request_head_parser (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    hrhp_in_if.sink         i_in,
    hrhp_out_if.source      o_out
);

    // parse phases
    localparam logic [3:0] PH_METHOD  = 4'd0;
    localparam logic [3:0] PH_PATH    = 4'd1;
    localparam logic [3:0] PH_QUERY   = 4'd2;
    localparam logic [3:0] PH_VERSION = 4'd3;
    localparam logic [3:0] PH_HEADERS = 4'd4;
    localparam logic [3:0] PH_DONE    = 4'd5;
    localparam logic [3:0] PH_ERROR   = 4'd6;

    // header line sections
    localparam logic [1:0] SEC_NAME   = 2'd0;
    localparam logic [1:0] SEC_SPACES = 2'd1;
    localparam logic [1:0] SEC_VALUE  = 2'd2;

    localparam logic [3:0] VPOS_DONE = 4'd8;
    localparam logic [3:0] VPOS_BAD  = 4'd15;

    // value match word: [3:0] count, [4] may be Keep-Alive, [5] may be close,
    // [6] space seen
    localparam int VM_KA = 4;
    localparam int VM_CL = 5;
    localparam int VM_SP = 6;

    // parse state
    logic [3:0]  r_phase;
    logic [47:0] r_mchars;
    logic [2:0]  r_mlen;
    logic [2:0]  r_mfound;
    logic [3:0]  r_vpos;
    logic [1:0]  r_vfound;
    logic        r_cr;
    logic [1:0]  r_sec;
    logic [3:0]  r_npos;
    logic        r_nmis;
    logic [7:0]  r_vm;
    logic [1:0]  r_conn;

    logic [3:0]  n_phase;
    logic [47:0] n_mchars;
    logic [2:0]  n_mlen;
    logic [2:0]  n_mfound;
    logic [3:0]  n_vpos;
    logic [1:0]  n_vfound;
    logic        n_cr;
    logic [1:0]  n_sec;
    logic [3:0]  n_npos;
    logic        n_nmis;
    logic [7:0]  n_vm;
    logic [1:0]  n_conn;

    // state as seen by this byte, after an optional start_new clear
    logic [3:0]  s_phase;
    logic [47:0] s_mchars;
    logic [2:0]  s_mlen;
    logic [2:0]  s_mfound;
    logic [3:0]  s_vpos;
    logic [1:0]  s_vfound;
    logic        s_cr;
    logic [1:0]  s_sec;
    logic [3:0]  s_npos;
    logic        s_nmis;
    logic [7:0]  s_vm;
    logic [1:0]  s_conn;

    logic        r_out_valid;
    hrhp_pkg::t_out_item r_out;

    logic        w_in_acc;
    logic        w_clr;
    logic [7:0]  w_b;
    logic [2:0]  w_role;
    logic [2:0]  w_ev;
    logic        w_ka;
    logic [3:0]  w_vp;

    assign w_b      = i_in.payload.data_byte;
    assign w_clr    = i_in.payload.start_new;
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_in_acc = i_in.valid && i_in.ready;

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

    assign s_phase  = w_clr ? PH_METHOD : r_phase;
    assign s_mchars = w_clr ? 48'd0 : r_mchars;
    assign s_mlen   = w_clr ? 3'd0 : r_mlen;
    assign s_mfound = w_clr ? hrhp_pkg::METH_INVALID : r_mfound;
    assign s_vpos   = w_clr ? 4'd0 : r_vpos;
    assign s_vfound = w_clr ? hrhp_pkg::VER_UNKNOWN : r_vfound;
    assign s_cr     = w_clr ? 1'b0 : r_cr;
    assign s_sec    = w_clr ? SEC_NAME : r_sec;
    assign s_npos   = w_clr ? 4'd0 : r_npos;
    assign s_nmis   = w_clr ? 1'b0 : r_nmis;
    assign s_vm     = w_clr ? 8'd0 : r_vm;
    assign s_conn   = w_clr ? hrhp_pkg::CONN_ABSENT : r_conn;

    // exact method lookup on the collected bytes
    function automatic logic [2:0] lookup_method(input logic [2:0]  len,
                                                 input logic [47:0] chars);
        logic [2:0] m;
        m = hrhp_pkg::METH_INVALID;
        if (len == 3'd3 && chars == hrhp_pkg::TXT_GET)         m = hrhp_pkg::METH_GET;
        else if (len == 3'd4 && chars == hrhp_pkg::TXT_POST)   m = hrhp_pkg::METH_POST;
        else if (len == 3'd4 && chars == hrhp_pkg::TXT_HEAD)   m = hrhp_pkg::METH_HEAD;
        else if (len == 3'd3 && chars == hrhp_pkg::TXT_PUT)    m = hrhp_pkg::METH_PUT;
        else if (len == 3'd6 && chars == hrhp_pkg::TXT_DELETE) m = hrhp_pkg::METH_DELETE;
        return m;
    endfunction

    function automatic logic [1:0] classify_value(input logic [7:0] vm);
        logic [1:0] k;
        if (vm[VM_KA] && vm[3:0] == 4'd10)     k = hrhp_pkg::CONN_KA;
        else if (vm[VM_CL] && vm[3:0] == 4'd5) k = hrhp_pkg::CONN_CLOSE;
        else                                   k = hrhp_pkg::CONN_OTHER;
        return k;
    endfunction

    always_comb begin
        n_phase  = s_phase;
        n_mchars = s_mchars;
        n_mlen   = s_mlen;
        n_mfound = s_mfound;
        n_vpos   = s_vpos;
        n_vfound = s_vfound;
        n_cr     = s_cr;
        n_sec    = s_sec;
        n_npos   = s_npos;
        n_nmis   = s_nmis;
        n_vm     = s_vm;
        n_conn   = s_conn;
        w_role   = hrhp_pkg::ROLE_IGNORED;
        w_ev     = hrhp_pkg::EV_NONE;
        w_ka     = 1'b0;
        w_vp     = s_vm[3:0];

        case (s_phase)
            PH_METHOD: begin
                if (w_b == hrhp_pkg::CH_SPACE) begin
                    w_role   = hrhp_pkg::ROLE_DELIM;
                    n_mfound = lookup_method(s_mlen, s_mchars);
                    if (n_mfound != hrhp_pkg::METH_INVALID) begin
                        n_phase = PH_PATH;
                    end else begin
                        w_ev    = hrhp_pkg::EV_ERROR;
                        n_phase = PH_ERROR;
                    end
                end else if (w_b == hrhp_pkg::CH_CR) begin
                    w_role  = hrhp_pkg::ROLE_DELIM;
                    w_ev    = hrhp_pkg::EV_ERROR;
                    n_phase = PH_ERROR;
                end else begin
                    w_role = hrhp_pkg::ROLE_METHOD;
                    if (s_mlen < 3'd6) begin
                        n_mchars = {s_mchars[39:0], w_b};
                        n_mlen   = s_mlen + 3'd1;
                    end else begin
                        n_mlen = 3'd7;  // too long for any method
                    end
                end
            end

            PH_PATH, PH_QUERY: begin
                if (w_b == hrhp_pkg::CH_SPACE) begin
                    w_role   = hrhp_pkg::ROLE_DELIM;
                    n_phase  = PH_VERSION;
                    n_vpos   = 4'd0;
                    n_vfound = hrhp_pkg::VER_UNKNOWN;
                end else if (w_b == hrhp_pkg::CH_CR) begin
                    w_role  = hrhp_pkg::ROLE_DELIM;
                    w_ev    = hrhp_pkg::EV_ERROR;
                    n_phase = PH_ERROR;
                end else if (w_b == hrhp_pkg::CH_QMARK) begin
                    w_role  = hrhp_pkg::ROLE_QUERY;
                    n_phase = PH_QUERY;
                end else begin
                    w_role = (s_phase == PH_PATH) ? hrhp_pkg::ROLE_PATH
                                                  : hrhp_pkg::ROLE_QUERY;
                end
            end

            PH_VERSION: begin
                if (s_cr) begin
                    n_cr = 1'b0;
                    if (w_b == hrhp_pkg::CH_LF && s_vpos == VPOS_DONE) begin
                        w_role  = hrhp_pkg::ROLE_DELIM;
                        w_ev    = hrhp_pkg::EV_REQ_LINE;
                        n_phase = PH_HEADERS;
                        n_sec   = SEC_NAME;
                        n_npos  = 4'd0;
                        n_nmis  = 1'b0;
                        n_vm    = 8'd0;
                    end else begin
                        w_role  = (w_b == hrhp_pkg::CH_LF) ? hrhp_pkg::ROLE_DELIM
                                                           : hrhp_pkg::ROLE_IGNORED;
                        w_ev    = hrhp_pkg::EV_ERROR;
                        n_phase = PH_ERROR;
                    end
                end else if (w_b == hrhp_pkg::CH_CR) begin
                    n_cr   = 1'b1;
                    w_role = hrhp_pkg::ROLE_DELIM;
                end else begin
                    w_role = hrhp_pkg::ROLE_VERSION;
                    if (s_vpos < 4'd7 && w_b == hrhp_pkg::ver_char(s_vpos)) begin
                        n_vpos = s_vpos + 4'd1;
                    end else if (s_vpos == 4'd7 && (w_b == hrhp_pkg::CH_ZERO ||
                                                    w_b == hrhp_pkg::CH_ONE)) begin
                        n_vfound = (w_b == hrhp_pkg::CH_ONE) ? hrhp_pkg::VER_1_1
                                                             : hrhp_pkg::VER_1_0;
                        n_vpos   = VPOS_DONE;
                    end else begin
                        n_vpos   = VPOS_BAD;
                        n_vfound = hrhp_pkg::VER_UNKNOWN;
                    end
                end
            end

            PH_HEADERS: begin
                if (s_cr) begin
                    n_cr = 1'b0;
                    if (w_b == hrhp_pkg::CH_LF) begin
                        w_role = hrhp_pkg::ROLE_DELIM;
                        if (s_sec == SEC_NAME) begin
                            // colon-less line, the empty one included: end of head
                            w_ev    = hrhp_pkg::EV_COMPLETE;
                            n_phase = PH_DONE;
                            w_ka    = (s_conn == hrhp_pkg::CONN_KA) ||
                                      (s_vfound == hrhp_pkg::VER_1_1 &&
                                       s_conn != hrhp_pkg::CONN_CLOSE);
                        end else begin
                            w_ev = hrhp_pkg::EV_HDR_LINE;
                            if (!s_nmis && s_npos == 4'd10) begin
                                n_conn = classify_value(s_vm);
                            end
                            n_sec  = SEC_NAME;
                            n_npos = 4'd0;
                            n_nmis = 1'b0;
                            n_vm   = 8'd0;
                        end
                    end else begin
                        // lone CR
                        w_role  = hrhp_pkg::ROLE_IGNORED;
                        w_ev    = hrhp_pkg::EV_ERROR;
                        n_phase = PH_ERROR;
                    end
                end else if (w_b == hrhp_pkg::CH_CR) begin
                    n_cr   = 1'b1;
                    w_role = hrhp_pkg::ROLE_DELIM;
                end else if (s_sec == SEC_NAME) begin
                    if (w_b == hrhp_pkg::CH_COLON) begin
                        w_role = hrhp_pkg::ROLE_DELIM;
                        n_sec  = SEC_SPACES;
                        n_vm   = 8'd0;
                        n_vm[VM_KA] = 1'b1;
                        n_vm[VM_CL] = 1'b1;
                    end else begin
                        w_role = hrhp_pkg::ROLE_HNAME;
                        if (!s_nmis && s_npos < 4'd10 &&
                            w_b == hrhp_pkg::conn_char(s_npos)) begin
                            n_npos = s_npos + 4'd1;
                        end else begin
                            n_nmis = 1'b1;
                        end
                    end
                end else if (s_sec == SEC_SPACES && w_b == hrhp_pkg::CH_SPACE) begin
                    w_role = hrhp_pkg::ROLE_IGNORED;
                end else begin
                    n_sec  = SEC_VALUE;
                    w_role = hrhp_pkg::ROLE_HVALUE;
                    // any text after an interior space spoils both matches
                    if (w_b == hrhp_pkg::CH_SPACE) begin
                        n_vm[VM_SP] = 1'b1;
                    end else if (s_vm[VM_SP]) begin
                        n_vm[VM_KA] = 1'b0;
                        n_vm[VM_CL] = 1'b0;
                    end else begin
                        if (!(w_vp < 4'd10 && w_b == hrhp_pkg::ka_char(w_vp))) begin
                            n_vm[VM_KA] = 1'b0;
                        end
                        if (!(w_vp < 4'd5 && w_b == hrhp_pkg::close_char(w_vp))) begin
                            n_vm[VM_CL] = 1'b0;
                        end
                        if (w_vp < 4'd15) begin
                            n_vm[3:0] = w_vp + 4'd1;
                        end
                    end
                end
            end

            default: begin
                // done, error and unused codes
                w_role = hrhp_pkg::ROLE_IGNORED;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_METHOD;
            r_mchars <= 48'd0;
            r_mlen   <= 3'd0;
            r_mfound <= hrhp_pkg::METH_INVALID;
            r_vpos   <= 4'd0;
            r_vfound <= hrhp_pkg::VER_UNKNOWN;
            r_cr     <= 1'b0;
            r_sec    <= SEC_NAME;
            r_npos   <= 4'd0;
            r_nmis   <= 1'b0;
            r_vm     <= 8'd0;
            r_conn   <= hrhp_pkg::CONN_ABSENT;
        end else if (w_in_acc) begin
            r_phase  <= n_phase;
            r_mchars <= n_mchars;
            r_mlen   <= n_mlen;
            r_mfound <= n_mfound;
            r_vpos   <= n_vpos;
            r_vfound <= n_vfound;
            r_cr     <= n_cr;
            r_sec    <= n_sec;
            r_npos   <= n_npos;
            r_nmis   <= n_nmis;
            r_vm     <= n_vm;
            r_conn   <= n_conn;
        end
    end

    // output register; refilled in the cycle it drains
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_out.byte_out     <= w_b;
            r_out.byte_role    <= w_role;
            r_out.event_code   <= w_ev;
            r_out.method_code  <= n_mfound;
            r_out.version_code <= n_vfound;
            r_out.keep_alive   <= w_ka;
        end
    end

    a_complete_is_delim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.event_code == hrhp_pkg::EV_COMPLETE)
        |-> r_out.byte_role == hrhp_pkg::ROLE_DELIM)
        else $error("request complete not on a delimiter byte");

    a_ka_only_on_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.keep_alive)
        |-> r_out.event_code == hrhp_pkg::EV_COMPLETE)
        else $error("keep_alive outside request complete");

    a_error_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && w_ev == hrhp_pkg::EV_ERROR) |=> r_phase == PH_ERROR)
        else $error("error event without entering error phase");

    a_method_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PATH || r_phase == PH_QUERY || r_phase == PH_VERSION ||
         r_phase == PH_HEADERS || r_phase == PH_DONE)
        |-> r_mfound != hrhp_pkg::METH_INVALID)
        else $error("past the method with no valid method");

    a_version_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vpos == VPOS_DONE) |-> r_vfound != hrhp_pkg::VER_UNKNOWN)
        else $error("full version text without a version code");

endmodule

`default_nettype wire
